// File: sv/data_section_rle_decoder_top_macros.svh
`ifndef DATA_SECTION_RLE_DECODER_TOP_MACROS_SVH
`define DATA_SECTION_RLE_DECODER_TOP_MACROS_SVH

// same-cycle implication on clk, off during rst
`define DRLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drle check failed");

// next-cycle implication on clk, off during rst
`define DRLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drle check failed");

`endif

// File: sv/drle_pkg.sv
`timescale 1ns / 1ps

package drle_pkg;

  localparam int unsigned PC_W  = 5;
  localparam int unsigned CNT_W = 7;

  localparam logic [2:0] KIND_IDLE = 3'd0;
  localparam logic [2:0] KIND_T1   = 3'd1;
  localparam logic [2:0] KIND_T2   = 3'd2;
  localparam logic [2:0] KIND_T3   = 3'd3;
  localparam logic [2:0] KIND_T4   = 3'd4;
  localparam logic [2:0] KIND_REP  = 3'd5;
  localparam logic [2:0] KIND_LIT  = 3'd6;

  // microprogram entry points
  localparam logic [PC_W-1:0] A_T1   = 5'd0;
  localparam logic [PC_W-1:0] A_T2   = 5'd6;
  localparam logic [PC_W-1:0] A_T3   = 5'd11;
  localparam logic [PC_W-1:0] A_T4   = 5'd15;
  localparam logic [PC_W-1:0] A_BYTE = 5'd18;
  localparam logic [PC_W-1:0] A_T3M  = 5'd19;
  localparam logic [PC_W-1:0] A_T4L  = 5'd21;
  localparam logic [PC_W-1:0] A_RUNB = 5'd23;
  localparam logic [PC_W-1:0] A_RUN0 = 5'd24;
  localparam logic [PC_W-1:0] A_RUNF = 5'd25;
  localparam logic [PC_W-1:0] A_FLAG = 5'd26;

  typedef struct packed {
    logic       valid;
    logic       use_byte;
    logic [7:0] cval;
    logic       rpt;
    logic       fin;
  } cw_t;

  typedef struct packed {
    logic             go;
    logic [PC_W-1:0]  entry;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       data;
    logic             flg_end;
    logic             flg_bad;
    logic             flg_prem;
  } start_t;

  function automatic cw_t drle_rom(input logic [PC_W-1:0] addr);
    cw_t cw;
    cw = '{valid: 1'b1, use_byte: 1'b0, cval: 8'h00, rpt: 1'b0, fin: 1'b0};
    case (addr)
      5'd0, 5'd1, 5'd2, 5'd3: ;
      5'd4: cw.cval = 8'hFF;
      5'd5: begin
        cw.cval = 8'hFF;
        cw.fin  = 1'b1;
      end
      5'd6, 5'd7, 5'd8, 5'd9: ;
      5'd10: begin
        cw.cval = 8'hFF;
        cw.fin  = 1'b1;
      end
      5'd11: cw.cval = 8'hA9;
      5'd12: cw.cval = 8'hF0;
      5'd13: ;
      5'd14: cw.fin = 1'b1;
      5'd15: cw.cval = 8'hA9;
      5'd16: cw.cval = 8'hF0;
      5'd17: cw.fin = 1'b1;
      5'd18: begin
        cw.use_byte = 1'b1;
        cw.fin      = 1'b1;
      end
      5'd19: cw.use_byte = 1'b1;
      5'd20: cw.fin = 1'b1;
      5'd21: ;
      5'd22: begin
        cw.use_byte = 1'b1;
        cw.fin      = 1'b1;
      end
      5'd23: begin
        cw.use_byte = 1'b1;
        cw.rpt      = 1'b1;
        cw.fin      = 1'b1;
      end
      5'd24: begin
        cw.rpt = 1'b1;
        cw.fin = 1'b1;
      end
      5'd25: begin
        cw.cval = 8'hFF;
        cw.rpt  = 1'b1;
        cw.fin  = 1'b1;
      end
      default: begin
        cw.valid = 1'b0;
        cw.fin   = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: sv/drle_dispatch.sv
`timescale 1ns / 1ps

module drle_dispatch (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           first_of_section,
  input  logic           last_of_section,
  output drle_pkg::start_t start
);
  import drle_pkg::*;

  localparam logic [7:0] C_END  = 8'h00;
  localparam logic [7:0] C_TPL4 = 8'h04;
  localparam logic [7:0] C_FF   = 8'h10;
  localparam logic [7:0] C_REP  = 8'h20;
  localparam logic [7:0] C_ZERO = 8'h40;
  localparam logic [7:0] C_LIT  = 8'h80;

  logic [2:0] pending_kind;
  logic [7:0] remaining_count;
  logic       halted;

  logic [2:0] pending_kind_next;
  logic [7:0] remaining_count_next;
  logic       halted_next;

  logic [2:0] kind_eff;
  logic [2:0] kind_c;
  logic [7:0] rem_eff;
  logic       halt_eff;
  logic       has_prog;
  logic       f_end;
  logic       f_bad;
  logic       f_prem;
  logic [PC_W-1:0]  entry;
  logic [CNT_W-1:0] cnt;
  logic [7:0] ops;
  logic [7:0] idx;

  function automatic logic [7:0] tpl_ops(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      KIND_T1: r = 8'd2;
      KIND_T2: r = 8'd3;
      KIND_T3: r = 8'd3;
      KIND_T4: r = 8'd4;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    kind_eff = first_of_section ? KIND_IDLE : pending_kind;
    rem_eff  = first_of_section ? 8'd0 : remaining_count;
    halt_eff = first_of_section ? 1'b0 : halted;
    kind_c   = (kind_eff > KIND_LIT || rem_eff == 8'd0) ? KIND_IDLE : kind_eff;
    pending_kind_next    = kind_eff;
    remaining_count_next = rem_eff;
    halted_next          = halt_eff;
    has_prog = 1'b0;
    f_end    = 1'b0;
    f_bad    = 1'b0;
    f_prem   = 1'b0;
    entry    = A_FLAG;
    cnt      = '0;
    ops      = tpl_ops(kind_c);
    idx      = ops - rem_eff;
    if (!halt_eff) begin
      pending_kind_next = kind_c;
      if (kind_c == KIND_IDLE) begin
        if (in_byte == C_END) begin
          f_end       = 1'b1;
          halted_next = 1'b1;
        end else if (in_byte <= C_TPL4) begin
          has_prog = 1'b1;
          case (in_byte[2:0])
            KIND_T1: entry = A_T1;
            KIND_T2: entry = A_T2;
            KIND_T3: entry = A_T3;
            default: entry = A_T4;
          endcase
          pending_kind_next    = in_byte[2:0];
          remaining_count_next = tpl_ops(in_byte[2:0]);
        end else if (in_byte < C_FF) begin
          f_bad       = 1'b1;
          halted_next = 1'b1;
        end else if (in_byte >= C_LIT) begin
          pending_kind_next    = KIND_LIT;
          remaining_count_next = in_byte - C_LIT + 8'd1;
        end else if (in_byte >= C_ZERO) begin
          has_prog = 1'b1;
          entry    = A_RUN0;
          cnt      = CNT_W'(in_byte - C_ZERO) + CNT_W'(1);
        end else if (in_byte >= C_REP) begin
          pending_kind_next    = KIND_REP;
          remaining_count_next = in_byte - C_REP + 8'd2;
        end else begin
          has_prog = 1'b1;
          entry    = A_RUNF;
          cnt      = CNT_W'(in_byte - C_FF) + CNT_W'(1);
        end
      end else if (kind_c == KIND_REP) begin
        has_prog             = 1'b1;
        entry                = A_RUNB;
        cnt                  = rem_eff[CNT_W-1:0];
        remaining_count_next = 8'd0;
        pending_kind_next    = KIND_IDLE;
      end else begin
        has_prog = 1'b1;
        if (kind_c == KIND_T4 && idx == 8'd3) begin
          entry = A_T4L;
        end else if (kind_c == KIND_T3 && idx == 8'd1) begin
          entry = A_T3M;
        end else begin
          entry = A_BYTE;
        end
        remaining_count_next = rem_eff - 8'd1;
        if (remaining_count_next == 8'd0) begin
          pending_kind_next = KIND_IDLE;
        end
      end
      if (last_of_section && !halted_next) begin
        f_prem      = 1'b1;
        halted_next = 1'b1;
      end
    end
    if (!has_prog) begin
      entry = A_FLAG;
    end
  end

  assign start.go       = accept && !halt_eff && (has_prog || f_end || f_bad || f_prem);
  assign start.entry    = entry;
  assign start.cnt      = cnt;
  assign start.data     = in_byte;
  assign start.flg_end  = f_end;
  assign start.flg_bad  = f_bad;
  assign start.flg_prem = f_prem;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind    <= KIND_IDLE;
      remaining_count <= 8'd0;
      halted          <= 1'b0;
    end else if (accept) begin
      pending_kind    <= pending_kind_next;
      remaining_count <= remaining_count_next;
      halted          <= halted_next;
    end
  end

endmodule

// File: sv/drle_seq.sv
`timescale 1ns / 1ps
`include "data_section_rle_decoder_top_macros.svh"

module drle_seq (
  input  logic             clk,
  input  logic             rst,
  input  drle_pkg::start_t start,
  output logic             busy,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,  // out_byte
  output logic             m_tlast,
  output logic [3:0]       m_tuser   // byte_valid, end_seen, bad_code, premature_end
);
  import drle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state;
  logic [PC_W-1:0]  pc;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       data;
  logic             flg_end;
  logic             flg_bad;
  logic             flg_prem;

  cw_t  cw;
  logic step;
  logic is_fin;

  assign cw     = drle_rom(pc);
  assign step   = (state == ST_RUN) && (!m_tvalid || m_tready);
  assign is_fin = cw.fin && (!cw.rpt || cnt == CNT_W'(1));
  assign busy   = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start.go) begin
            state <= ST_RUN;
            pc    <= start.entry;
            cnt   <= start.cnt;
          end
        end
        ST_RUN: begin
          if (step) begin
            if (is_fin) begin
              state <= ST_IDLE;
            end else if (cw.rpt) begin
              cnt <= cnt - CNT_W'(1);
            end else begin
              pc <= pc + PC_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.go && state == ST_IDLE) begin
      data     <= start.data;
      flg_end  <= start.flg_end;
      flg_bad  <= start.flg_bad;
      flg_prem <= start.flg_prem;
    end
    if (step) begin
      m_tdata <= cw.valid ? (cw.use_byte ? data : cw.cval) : 8'h00;
      m_tlast <= is_fin;
      m_tuser <= {flg_prem & is_fin, flg_bad & is_fin, flg_end & is_fin, cw.valid};
    end
  end

  `DRLE_ASSERT_IMP(a_start_when_idle, start.go, state == ST_IDLE)
  `DRLE_ASSERT_IMP(a_run_count_live, state == ST_RUN && cw.rpt, cnt != '0)
  `DRLE_ASSERT_IMP(a_flags_on_last, m_tvalid && m_tuser[3:1] != 3'b000, m_tlast)
  `DRLE_ASSERT_IMP(a_flag_only, m_tvalid && !m_tuser[0],
                   m_tlast && m_tdata == 8'h00 && m_tuser[3:1] != 3'b000)
  `DRLE_ASSERT_NXT(a_fin_to_idle, step && is_fin, state == ST_IDLE)

endmodule

// File: sv/data_section_rle_decoder_top.sv
`timescale 1ns / 1ps
// channel  | dir | tdata         | tuser                                       | tlast
// s_axis   | in  | [7:0] in_byte | [0] first_of_section                        | last_of_section
// m_axis   | out | [7:0] out_byte| [0] byte_valid [1] end_seen [2] bad_code    | last
//          |     |               | [3] premature_end                           |
// an item is taken while s_tready is high; one giving results then holds s_tready low
// until its last result is issued, one result per microcode step from the control rom
// an item giving no result does not hold s_tready low, halted or silent items included
// rst is synchronous and clears the decoder state, sequencer and output valid
// a stalled m_tready holds the sequencer on its current step

module data_section_rle_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic [0:0] s_tuser,   // first_of_section
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [3:0] m_tuser,   // byte_valid, end_seen, bad_code, premature_end
  output logic       m_tlast
);
  import drle_pkg::*;

  start_t start;
  logic   busy;
  logic   accept;

  assign s_tready = !busy && !rst;
  assign accept   = s_tvalid && s_tready;

  drle_dispatch u_dispatch (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .in_byte          (s_tdata),
    .first_of_section (s_tuser[0]),
    .last_of_section  (s_tlast),
    .start            (start)
  );

  drle_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
